@@ rtl/core/sfle_pkg.sv @@
// Shared types, constants and decode functions of the struct field layout engine.
// No dependencies; every other file of the block depends on this package.
package sfle_pkg;

    localparam int POINTER_BYTES   = 8;
    localparam int WIDE_CHAR_BYTES = 4;
    localparam int OFFSET_BITS     = 20;

    localparam int OFS_W   = OFFSET_BITS;
    localparam int OUT_W   = 20;
    localparam int ID_W    = 32;
    localparam int TYPE_W  = 5;
    localparam int CODE_W  = 3;
    localparam int COUNT_W = 12;
    localparam int MOFS_W  = 16;
    localparam int LG_W    = 3;
    localparam int SIZE_W  = $clog2((2 ** COUNT_W) * WIDE_CHAR_BYTES);

    localparam logic [OFS_W-1:0] OFS_BOUND = '1;

    localparam logic [LG_W-1:0] PTR_LG  = LG_W'($clog2(POINTER_BYTES));
    localparam logic [LG_W-1:0] WCHR_LG = LG_W'($clog2(WIDE_CHAR_BYTES));

    localparam logic [CODE_W-1:0] CODE_POW_MIN = 3'd1;
    localparam logic [CODE_W-1:0] CODE_POW_MAX = 3'd5;

    localparam logic [TYPE_W-1:0] TYPE_U8       = 5'd0;
    localparam logic [TYPE_W-1:0] TYPE_I8       = 5'd1;
    localparam logic [TYPE_W-1:0] TYPE_U16      = 5'd2;
    localparam logic [TYPE_W-1:0] TYPE_I16      = 5'd3;
    localparam logic [TYPE_W-1:0] TYPE_U32      = 5'd4;
    localparam logic [TYPE_W-1:0] TYPE_I32      = 5'd5;
    localparam logic [TYPE_W-1:0] TYPE_U64      = 5'd6;
    localparam logic [TYPE_W-1:0] TYPE_I64      = 5'd7;
    localparam logic [TYPE_W-1:0] TYPE_FLOAT    = 5'd8;
    localparam logic [TYPE_W-1:0] TYPE_DOUBLE   = 5'd9;
    localparam logic [TYPE_W-1:0] TYPE_BOOL     = 5'd10;
    localparam logic [TYPE_W-1:0] TYPE_PTR      = 5'd11;
    localparam logic [TYPE_W-1:0] TYPE_FILL1    = 5'd12;
    localparam logic [TYPE_W-1:0] TYPE_FILL2    = 5'd13;
    localparam logic [TYPE_W-1:0] TYPE_FILL4    = 5'd14;
    localparam logic [TYPE_W-1:0] TYPE_FILL8    = 5'd15;
    localparam logic [TYPE_W-1:0] TYPE_FILL16   = 5'd16;
    localparam logic [TYPE_W-1:0] TYPE_FILL32   = 5'd17;
    localparam logic [TYPE_W-1:0] TYPE_FILLN    = 5'd18;
    localparam logic [TYPE_W-1:0] TYPE_CHR_PTR  = 5'd19;
    localparam logic [TYPE_W-1:0] TYPE_WCHR_PTR = 5'd20;
    localparam logic [TYPE_W-1:0] TYPE_CHR_ARR  = 5'd21;
    localparam logic [TYPE_W-1:0] TYPE_WCHR_ARR = 5'd22;

    typedef struct packed {
        logic            en;
        logic [LG_W-1:0] lg;
    } sfle_pow_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [LG_W-1:0]   lg;
    } sfle_shape_t;

    typedef struct packed {
        logic              enabled;
        logic              manual;
        logic [MOFS_W-1:0] manual_ofs;
        logic [SIZE_W-1:0] size;
        logic [LG_W-1:0]   align_lg;
        logic              hit;
        logic              last;
    } sfle_entry_t;

    function automatic sfle_pow_t code_to_pow(input logic [CODE_W-1:0] code);
        sfle_pow_t p;
        p.en = (code >= CODE_POW_MIN) && (code <= CODE_POW_MAX);
        p.lg = LG_W'(code - CODE_POW_MIN);
        return p;
    endfunction

    function automatic sfle_shape_t type_shape(input logic [TYPE_W-1:0] ftype,
                                               input logic [COUNT_W-1:0] chars,
                                               input logic [COUNT_W-1:0] filler);
        sfle_shape_t s;
        logic [COUNT_W-1:0] n_chars;
        logic [COUNT_W-1:0] n_fill;
        n_chars = (chars == '0) ? COUNT_W'(1) : chars;
        n_fill  = (filler == '0) ? COUNT_W'(1) : filler;
        unique case (ftype)
            TYPE_U8, TYPE_I8, TYPE_BOOL, TYPE_FILL1:
            begin
                s.size = SIZE_W'(1);
                s.lg   = LG_W'(0);
            end
            TYPE_U16, TYPE_I16:
            begin
                s.size = SIZE_W'(2);
                s.lg   = LG_W'(1);
            end
            TYPE_U32, TYPE_I32, TYPE_FLOAT:
            begin
                s.size = SIZE_W'(4);
                s.lg   = LG_W'(2);
            end
            TYPE_U64, TYPE_I64, TYPE_DOUBLE:
            begin
                s.size = SIZE_W'(8);
                s.lg   = LG_W'(3);
            end
            TYPE_PTR, TYPE_CHR_PTR, TYPE_WCHR_PTR:
            begin
                s.size = SIZE_W'(POINTER_BYTES);
                s.lg   = PTR_LG;
            end
            TYPE_FILL2:
            begin
                s.size = SIZE_W'(2);
                s.lg   = LG_W'(0);
            end
            TYPE_FILL4:
            begin
                s.size = SIZE_W'(4);
                s.lg   = LG_W'(0);
            end
            TYPE_FILL8:
            begin
                s.size = SIZE_W'(8);
                s.lg   = LG_W'(0);
            end
            TYPE_FILL16:
            begin
                s.size = SIZE_W'(16);
                s.lg   = LG_W'(0);
            end
            TYPE_FILL32:
            begin
                s.size = SIZE_W'(32);
                s.lg   = LG_W'(0);
            end
            TYPE_FILLN:
            begin
                s.size = SIZE_W'(n_fill);
                s.lg   = LG_W'(0);
            end
            TYPE_CHR_ARR:
            begin
                s.size = SIZE_W'(n_chars);
                s.lg   = LG_W'(0);
            end
            TYPE_WCHR_ARR:
            begin
                s.size = SIZE_W'(n_chars * WIDE_CHAR_BYTES);
                s.lg   = WCHR_LG;
            end
            default:
            begin
                s.size = SIZE_W'(1);
                s.lg   = LG_W'(0);
            end
        endcase
        return s;
    endfunction

    // Rounds up to a multiple of 2**lg; the top bit of the result flags a value past the bound.
    function automatic logic [OFS_W:0] align_up(input logic [OFS_W-1:0] v,
                                                input logic [LG_W-1:0] lg);
        logic [OFS_W:0] mask;
        logic [OFS_W:0] sum;
        mask = ((OFS_W+1)'(1) << lg) - (OFS_W+1)'(1);
        sum  = {1'b0, v} + mask;
        return sum & ~mask;
    endfunction

endpackage

@@ rtl/core/sfle_if.sv @@
// Request channels of the struct field layout engine: field descriptors and layout results.
// Depends on sfle_pkg for the field widths.
interface sfle_desc_if;
    logic                               valid;
    logic                               ready;
    logic [sfle_pkg::TYPE_W-1:0]        field_type;
    logic                               field_enabled;
    logic [sfle_pkg::CODE_W-1:0]        align_code;
    logic                               manual_flag;
    logic signed [sfle_pkg::MOFS_W-1:0] manual_offset;
    logic [sfle_pkg::COUNT_W-1:0]       char_count;
    logic [sfle_pkg::COUNT_W-1:0]       filler_bytes;
    logic [sfle_pkg::ID_W-1:0]          field_id;
    logic                               last_field;

    modport source (output valid, field_type, field_enabled, align_code, manual_flag,
                    manual_offset, char_count, filler_bytes, field_id, last_field,
                    input ready);
    modport sink (input valid, field_type, field_enabled, align_code, manual_flag,
                  manual_offset, char_count, filler_bytes, field_id, last_field,
                  output ready);
endinterface

interface sfle_result_if;
    logic                        valid;
    logic                        ready;
    logic [sfle_pkg::OUT_W-1:0]  field_offset;
    logic [sfle_pkg::OUT_W-1:0]  object_size;
    logic [sfle_pkg::OUT_W-1:0]  wanted_offset;
    logic                        found;
    logic                        record_done;
    logic                        overflow;

    modport source (output valid, field_offset, object_size, wanted_offset, found,
                    record_done, overflow, input ready);
    modport sink (input valid, field_offset, object_size, wanted_offset, found,
                  record_done, overflow, output ready);
endinterface

@@ rtl/core/sfle_front.sv @@
// Front end: accepts field descriptors and classifies them into size, alignment and match.
// Depends on sfle_pkg and sfle_desc_if.
module sfle_front (
    sfle_desc_if.sink                      desc,
    input  logic [sfle_pkg::CODE_W-1:0]    packing_code,
    input  logic [sfle_pkg::ID_W-1:0]      wanted_field_id,
    input  logic                           full,
    output logic                           push,
    output sfle_pkg::sfle_entry_t          entry
);
    import sfle_pkg::*;

    sfle_shape_t     shape;
    sfle_pow_t       over;
    sfle_pow_t       pack;
    logic [LG_W-1:0] lg_pick;
    logic [LG_W-1:0] lg_cap;

    assign desc.ready = !full;
    assign push       = desc.valid && !full;

    always_comb
    begin
        shape   = type_shape(desc.field_type, desc.char_count, desc.filler_bytes);
        over    = code_to_pow(desc.align_code);
        pack    = code_to_pow(packing_code);
        lg_pick = over.en ? over.lg : shape.lg;
        lg_cap  = (pack.en && (lg_pick > pack.lg)) ? pack.lg : lg_pick;

        entry.enabled    = desc.field_enabled;
        entry.manual     = desc.manual_flag;
        entry.manual_ofs = desc.manual_offset[MOFS_W-1] ? '0 : desc.manual_offset;
        entry.size       = shape.size;
        entry.align_lg   = lg_cap;
        entry.hit        = (desc.field_id == wanted_field_id);
        entry.last       = desc.last_field;
    end

endmodule

@@ rtl/core/sfle_queue.sv @@
// Two-entry queue that decouples the classifying front end from the placement back end.
// Depends on sfle_pkg for the entry type.
module sfle_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sfle_pkg::sfle_entry_t entry_in,
    input  logic                  pop,
    output sfle_pkg::sfle_entry_t entry_out,
    output logic                  empty,
    output logic                  full
);
    import sfle_pkg::*;

    sfle_entry_t mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign empty     = (count_reg == 2'd0);
    assign full      = (count_reg == 2'd2);
    assign entry_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

@@ rtl/core/sfle_back.sv @@
// Back end: places each classified field at the running cursor and closes records.
// Depends on sfle_pkg and sfle_result_if; holds the result in an output register.
module sfle_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sfle_pkg::sfle_entry_t       entry,
    input  logic                        empty,
    output logic                        pop,
    input  logic [sfle_pkg::CODE_W-1:0] packing_code,
    sfle_result_if.source               result
);
    import sfle_pkg::*;

    logic [OFS_W-1:0] cursor_reg;
    logic [OFS_W-1:0] cursor_next;
    logic [LG_W-1:0]  largest_reg;
    logic [LG_W-1:0]  largest_next;
    logic [OFS_W-1:0] moff_reg;
    logic [OFS_W-1:0] moff_next;
    logic             matched_reg;
    logic             matched_next;
    logic             sat_reg;
    logic             sat_next;

    logic             valid_reg;
    logic             valid_next;
    logic [OUT_W-1:0] offset_out_reg;
    logic [OUT_W-1:0] offset_out_next;
    logic [OUT_W-1:0] size_out_reg;
    logic [OUT_W-1:0] size_out_next;
    logic [OUT_W-1:0] want_out_reg;
    logic [OUT_W-1:0] want_out_next;
    logic             found_reg;
    logic             found_next;
    logic             done_reg;
    logic             done_next;
    logic             ovf_reg;
    logic             ovf_next;

    sfle_pow_t        pack;
    logic [OFS_W:0]   aligned_raw;
    logic [OFS_W-1:0] offset;
    logic             ofs_sat;
    logic [OFS_W:0]   end_raw;
    logic [OFS_W-1:0] end_val;
    logic [OFS_W-1:0] cur_a;
    logic [LG_W-1:0]  lg_a;
    logic [OFS_W-1:0] moff_a;
    logic             matched_a;
    logic             sat_a;
    logic             hit;
    logic [LG_W-1:0]  close_lg;
    logic [OFS_W:0]   close_raw;
    logic [OFS_W-1:0] close_val;
    logic             sat_b;

    assign pop          = !empty && (!valid_reg || result.ready);
    assign valid_next   = pop || (valid_reg && !result.ready);

    assign result.valid         = valid_reg;
    assign result.field_offset  = offset_out_reg;
    assign result.object_size   = size_out_reg;
    assign result.wanted_offset = want_out_reg;
    assign result.found         = found_reg;
    assign result.record_done   = done_reg;
    assign result.overflow      = ovf_reg;

    always_comb
    begin
        pack        = code_to_pow(packing_code);
        aligned_raw = align_up(cursor_reg, entry.align_lg);
        ofs_sat     = entry.enabled && !entry.manual && aligned_raw[OFS_W];
        if (!entry.enabled)
        begin
            offset = '0;
        end
        else if (entry.manual)
        begin
            offset = OFS_W'(entry.manual_ofs);
        end
        else
        begin
            offset = aligned_raw[OFS_W] ? OFS_BOUND : aligned_raw[OFS_W-1:0];
        end

        end_raw = {1'b0, offset} + (OFS_W+1)'(entry.size);
        end_val = end_raw[OFS_W] ? OFS_BOUND : end_raw[OFS_W-1:0];
        hit     = entry.enabled && entry.hit;

        if (entry.enabled)
        begin
            cur_a = (end_val > cursor_reg) ? end_val : cursor_reg;
            lg_a  = (entry.align_lg > largest_reg) ? entry.align_lg : largest_reg;
            sat_a = sat_reg || ofs_sat || end_raw[OFS_W];
        end
        else
        begin
            cur_a = cursor_reg;
            lg_a  = largest_reg;
            sat_a = sat_reg;
        end
        moff_a    = hit ? offset : moff_reg;
        matched_a = matched_reg || hit;

        close_lg  = (pack.en && (lg_a > pack.lg)) ? pack.lg : lg_a;
        close_raw = align_up(cur_a, close_lg);
        close_val = close_raw[OFS_W] ? OFS_BOUND : close_raw[OFS_W-1:0];
        sat_b     = sat_a || (entry.last && close_raw[OFS_W]);

        offset_out_next = OUT_W'(offset);
        size_out_next   = entry.last ? OUT_W'(close_val) : '0;
        want_out_next   = (entry.last && matched_a) ? OUT_W'(moff_a) : '0;
        found_next      = entry.last && matched_a;
        done_next       = entry.last;
        ovf_next        = sat_b;

        moff_next = moff_a;
        if (entry.last)
        begin
            cursor_next  = '0;
            largest_next = '0;
            matched_next = 1'b0;
            sat_next     = 1'b0;
        end
        else
        begin
            cursor_next  = cur_a;
            largest_next = lg_a;
            matched_next = matched_a;
            sat_next     = sat_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            cursor_reg  <= '0;
            largest_reg <= '0;
            moff_reg    <= '0;
            matched_reg <= 1'b0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                cursor_reg  <= cursor_next;
                largest_reg <= largest_next;
                moff_reg    <= moff_next;
                matched_reg <= matched_next;
                sat_reg     <= sat_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            offset_out_reg <= offset_out_next;
            size_out_reg   <= size_out_next;
            want_out_reg   <= want_out_next;
            found_reg      <= found_next;
            done_reg       <= done_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

@@ rtl/core/struct_field_layout_engine_unit.sv @@
// The struct field layout engine accepts one field descriptor per clock cycle while the
// queue is not full and returns one result per descriptor, in order. The front end decodes
// size, alignment and the id match; a two-entry queue carries the decoded field to the
// back end, whose cursor update sets the rate of one descriptor per cycle while the result
// side does not stall. The result of the descriptor flagged last also carries the padded
// object size and the offset of the queried field.
// Packing and the queried id are written through the APB port at byte addresses 0 and 4.
// Depends on sfle_pkg, sfle_if, sfle_front, sfle_queue and sfle_back.
module struct_field_layout_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    sfle_desc_if.sink   desc,
    sfle_result_if.source result
);
    import sfle_pkg::*;

    localparam logic REG_PACKING = 1'b0;
    localparam logic REG_WANTED  = 1'b1;

    logic [CODE_W-1:0] packing_reg;
    logic [CODE_W-1:0] packing_next;
    logic [ID_W-1:0]   wanted_reg;
    logic [ID_W-1:0]   wanted_next;
    logic              wr_en;

    sfle_entry_t       push_entry;
    sfle_entry_t       pop_entry;
    logic              push;
    logic              pop;
    logic              empty;
    logic              full;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        packing_next = packing_reg;
        wanted_next  = wanted_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_PACKING: packing_next = pwdata[CODE_W-1:0];
                REG_WANTED:  wanted_next  = pwdata[ID_W-1:0];
                default:     packing_next = packing_reg;
            endcase
        end
        unique case (paddr[2])
            REG_PACKING: prdata = 32'(packing_reg);
            REG_WANTED:  prdata = wanted_reg;
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packing_reg <= '0;
            wanted_reg  <= '0;
        end
        else
        begin
            packing_reg <= packing_next;
            wanted_reg  <= wanted_next;
        end
    end

    sfle_front u_front (
        .desc            (desc),
        .packing_code    (packing_reg),
        .wanted_field_id (wanted_reg),
        .full            (full),
        .push            (push),
        .entry           (push_entry)
    );

    sfle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry_in  (push_entry),
        .pop       (pop),
        .entry_out (pop_entry),
        .empty     (empty),
        .full      (full)
    );

    sfle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry        (pop_entry),
        .empty        (empty),
        .pop          (pop),
        .packing_code (packing_reg),
        .result       (result)
    );

endmodule
